[rtl/http_chunked_body_decoder_assert.svh]
// Assertion macros used by the checker file.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// Property checked while out of reset.
`define HCBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define HCBD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/hcbd_pkg.sv]
package hcbd_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_VT    = 8'h0B;
    localparam logic [7:0] C_FF    = 8'h0C;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_SPACE = 8'h20;

    // Input byte after classification
    typedef struct packed {
        logic       restart;
        logic [7:0] data;
        logic       is_lf;
        logic       is_blank;
        logic       is_hex;
        logic [3:0] digit;
        logic       is_zero;
        logic       is_x;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       body_done;
        logic       length_overflow;
    } t_result;

endpackage

[rtl/http_chunked_body_decoder.sv]
// Chunked body decoder: push one body byte per cycle while full is low, pop
// payload bytes and end-of-body / size-overflow markers. A byte is classified
// as it enters and waits in a two-entry queue; the decoding state machine
// takes one queued byte per cycle whenever the two-entry result queue has room.
// Sustained rate is one byte per cycle while results are popped; each result
// is registered in the result queue. full rises only when the result queue is
// held and both byte entries are occupied.
module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_restart,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_body_done,
    output logic       o_length_overflow
);

    t_item   item;
    logic    item_valid;
    logic    item_take;
    t_result res;
    t_result res_out;
    logic    res_push;
    logic    res_full;
    logic [$bits(t_result)-1:0] res_q;

    hcbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_in_byte    (i_in_byte),
        .i_restart    (i_restart),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_take  (item_take)
    );

    hcbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_take  (item_take),
        .i_res_room   (!res_full),
        .o_res        (res),
        .o_res_push   (res_push)
    );

    hcbd_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign res_out           = t_result'(res_q);
    assign o_out_byte        = res_out.out_byte;
    assign o_byte_valid      = res_out.byte_valid;
    assign o_body_done       = res_out.body_done;
    assign o_length_overflow = res_out.length_overflow;

endmodule

[rtl/hcbd_queue.sv]
module hcbd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + PW'(1);
            end
            if (rd_en) begin
                r_rd <= r_rd + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/hcbd_front.sv]
module hcbd_front
    import hcbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_in_byte,
    input  logic       i_restart,
    output t_item      o_item,
    output logic       o_item_valid,
    input  logic       i_item_take
);

    t_item cls;
    logic  empty;
    logic [$bits(t_item)-1:0] q_data;

    always_comb begin
        cls          = '0;
        cls.restart  = i_restart;
        cls.data     = i_in_byte;
        cls.is_lf    = (i_in_byte == C_LF);
        cls.is_blank = i_in_byte inside {C_SPACE, C_TAB, C_VT, C_FF, C_CR};
        cls.is_zero  = (i_in_byte == "0");
        cls.is_x     = i_in_byte inside {"x", "X"};
        if (i_in_byte inside {["0":"9"]}) begin
            cls.is_hex = 1'b1;
            cls.digit  = 4'(i_in_byte - "0");
        end else if (i_in_byte inside {["a":"f"]}) begin
            cls.is_hex = 1'b1;
            cls.digit  = 4'(i_in_byte - "a" + 8'd10);
        end else if (i_in_byte inside {["A":"F"]}) begin
            cls.is_hex = 1'b1;
            cls.digit  = 4'(i_in_byte - "A" + 8'd10);
        end
    end

    hcbd_queue #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .i_pop   (i_item_take),
        .o_data  (q_data),
        .o_empty (empty)
    );

    assign o_item       = t_item'(q_data);
    assign o_item_valid = !empty;

endmodule

[rtl/hcbd_back.sv]
module hcbd_back
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 31
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_item_valid,
    output logic    o_item_take,
    input  logic    i_res_room,
    output t_result o_res,
    output logic    o_res_push
);

    typedef enum logic [2:0] {
        PH_START,
        PH_DIGITS,
        PH_IGNORE,
        PH_DATA,
        PH_CRLF,
        PH_TRAILER,
        PH_DONE
    } t_phase;

    localparam logic [1:0] PFX_NONE = 2'd0;
    localparam logic [1:0] PFX_ZERO = 2'd1;
    localparam logic [1:0] PFX_X    = 2'd2;
    localparam logic [1:0] PFX_GONE = 2'd3;
    localparam logic [1:0] CRLF_BYTES = 2'd2;
    localparam logic [SIZE_BITS-1:0] ONE = SIZE_BITS'(1);

    t_phase               r_phase, n_phase, ph;
    logic [SIZE_BITS-1:0] r_acc, n_acc, acc;
    logic [SIZE_BITS-1:0] r_rem, n_rem, rem;
    logic [SIZE_BITS-1:0] rem_dec;
    logic [SIZE_BITS-1:0] acc_dig;
    logic [1:0]           r_crlf, n_crlf, crlf;
    logic [1:0]           r_prefix, n_prefix, prefix;
    logic                 r_ovf, n_ovf, ovf;
    logic                 sat;
    logic                 fire;
    logic                 res_valid;
    t_result              res;

    assign fire        = i_item_valid && i_res_room;
    assign o_item_take = fire;
    assign o_res       = res;
    assign o_res_push  = fire && res_valid;

    always_comb begin
        // restart clears state before the byte is handled
        ph     = i_item.restart ? PH_START : r_phase;
        acc    = i_item.restart ? '0 : r_acc;
        rem    = i_item.restart ? '0 : r_rem;
        crlf   = i_item.restart ? '0 : r_crlf;
        prefix = i_item.restart ? PFX_NONE : r_prefix;
        ovf    = i_item.restart ? 1'b0 : r_ovf;

        // product would pass the top when any of the upper four bits is set
        sat     = |acc[SIZE_BITS-1:SIZE_BITS-4];
        acc_dig = sat ? '1 : {acc[SIZE_BITS-5:0], i_item.digit};
        rem_dec = rem - ONE;

        n_phase   = ph;
        n_acc     = acc;
        n_rem     = rem;
        n_crlf    = crlf;
        n_prefix  = prefix;
        n_ovf     = ovf;
        res       = '0;
        res_valid = 1'b0;

        case (ph)
            PH_START, PH_DIGITS, PH_IGNORE: begin
                if (i_item.is_lf) begin
                    if (ovf) begin
                        res.length_overflow = 1'b1;
                        res_valid           = 1'b1;
                    end
                    if (acc == '0) begin
                        n_phase = PH_TRAILER;
                    end else begin
                        n_rem   = acc;
                        n_phase = PH_DATA;
                    end
                end else if (ph == PH_START) begin
                    if (!i_item.is_blank) begin
                        if (!i_item.is_hex) begin
                            n_phase = PH_IGNORE;
                        end else begin
                            n_acc    = acc_dig;
                            n_ovf    = ovf | sat;
                            n_prefix = i_item.is_zero ? PFX_ZERO : PFX_GONE;
                            n_phase  = PH_DIGITS;
                        end
                    end
                end else if (ph == PH_DIGITS) begin
                    if (prefix == PFX_ZERO && i_item.is_x) begin
                        n_prefix = PFX_X;
                    end else if (!i_item.is_hex) begin
                        n_phase = PH_IGNORE;
                    end else begin
                        n_acc    = acc_dig;
                        n_ovf    = ovf | sat;
                        n_prefix = PFX_GONE;
                    end
                end
            end
            PH_DATA: begin
                res.out_byte   = i_item.data;
                res.byte_valid = 1'b1;
                res_valid      = 1'b1;
                n_rem          = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = PH_CRLF;
                    n_crlf  = CRLF_BYTES;
                end
            end
            PH_CRLF: begin
                // drop the two bytes after the chunk, then open a new size line
                if (crlf != '0) begin
                    n_crlf = crlf - 2'd1;
                end
                if (n_crlf == '0) begin
                    n_phase  = PH_START;
                    n_acc    = '0;
                    n_prefix = PFX_NONE;
                    n_ovf    = 1'b0;
                end
            end
            PH_TRAILER: begin
                if (i_item.is_lf) begin
                    res.body_done = 1'b1;
                    res_valid     = 1'b1;
                    n_phase       = PH_DONE;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_acc    <= '0;
            r_rem    <= '0;
            r_crlf   <= '0;
            r_prefix <= PFX_NONE;
            r_ovf    <= 1'b0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_rem    <= n_rem;
            r_crlf   <= n_crlf;
            r_prefix <= n_prefix;
            r_ovf    <= n_ovf;
        end
    end

endmodule

[rtl/hcbd_checker.sv]
`include "http_chunked_body_decoder_assert.svh"

module hcbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic [7:0] i_in_byte,
    input logic       i_restart,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_body_done,
    input logic       o_length_overflow
);

    // every result carries exactly one kind of marker
    `HCBD_ASSERT(a_one_kind, !empty |-> ((o_byte_valid + o_body_done + o_length_overflow) == 2'd1), "result with other than one marker")

    `HCBD_ASSERT(a_marker_zero_byte, (!empty && !o_byte_valid) |-> (o_out_byte == 8'd0), "marker result with nonzero byte")

    `HCBD_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (empty && !full), "queues not cleared by reset")

    `HCBD_ASSERT(a_hold_result, (!empty && !pop) |=> (!empty && $stable(o_out_byte)), "waiting result lost")

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);
